[rtl/tcp_option_mptcp_finder_assert.svh]
// Assertion helpers for the MPTCP option finder. Both sample on clk and are
// disabled while rst_n is low.
`ifndef TCP_OPTION_MPTCP_FINDER_ASSERT_SVH
`define TCP_OPTION_MPTCP_FINDER_ASSERT_SVH

// Same-cycle implication.
`define TOMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TOMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tomf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tomf_pkg;

    localparam logic [7:0] KIND_END   = 8'd0;
    localparam logic [7:0] KIND_NOOP  = 8'd1;
    localparam logic [7:0] KIND_MPTCP = 8'd30;

    localparam int SUBTYPE_SHIFT = 4;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_SUB,
        PH_SKIP,
        PH_DONE
    } phase_t;

endpackage

`default_nettype wire

[rtl/tomf_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Option byte stream
interface tomf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] option_byte;
    logic       last_byte;
    logic       area_empty;

    modport source (output valid, output option_byte, output last_byte, output area_empty,
                    input ready);
    modport sink   (input valid, input option_byte, input last_byte, input area_empty,
                    output ready);
endinterface

// One result per options area
interface tomf_out_if;
    logic       valid;
    logic       ready;
    logic       found_mptcp;
    logic [3:0] found_subtype;
    logic       subtype_matches;
    logic       malformed;

    modport source (output valid, output found_mptcp, output found_subtype,
                    output subtype_matches, output malformed, input ready);
    modport sink   (input valid, input found_mptcp, input found_subtype,
                    input subtype_matches, input malformed, output ready);
endinterface

// Target subtype register write
interface tomf_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] target_subtype;

    modport source (output valid, output target_subtype, input ready);
    modport sink   (input valid, input target_subtype, output ready);
endinterface

`default_nettype wire

[rtl/tcp_option_mptcp_finder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                              Request
// -------   ---  ---------------------------------------------------  ----------------
// opts      in   option_byte[7:0], last_byte, area_empty               one option byte
// result    out  found_mptcp, found_subtype[3:0], subtype_matches,     one options area
//                malformed
// cfg       in   target_subtype[3:0]                                   register write
//
// One option byte is taken per cycle while opts is not stalled; the walk state updates in the same cycle.
// The result of an area is registered and shows in the cycle after its last byte
// (or an empty-area request) is taken.
// A waiting result stalls opts only while result.ready is low.
// rst_n clears the walk, the result valid flag and target_subtype asynchronously.
// cfg is always ready.

`include "tcp_option_mptcp_finder_assert.svh"

module tcp_option_mptcp_finder #(
    parameter int MAX_OPTION_BYTES = 40
) (
    input  wire               clk,
    input  wire               rst_n,
    tomf_cfg_if.sink          cfg,
    tomf_in_if.sink           opts,
    tomf_out_if.source        result
);

    localparam int CNT_W = $clog2(MAX_OPTION_BYTES + 1);

    tomf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       skip_reg, skip_next;
    logic             in_mptcp_reg, in_mptcp_next;
    logic             found_reg, found_next;
    logic [3:0]       sub_reg, sub_next;
    logic             mal_reg, mal_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       target_reg;

    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [3:0]       out_sub_reg, out_sub_next;
    logic             out_match_reg, out_match_next;
    logic             out_mal_reg, out_mal_next;

    logic             accept;

    // working values of one step
    tomf_pkg::phase_t ph_w;
    logic [7:0]       skip_w;
    logic             inmp_w;
    logic             found_w;
    logic [3:0]       sub_w;
    logic             mal_w;
    logic [CNT_W-1:0] cnt_w;
    logic [7:0]       b;

    assign cfg.ready    = 1'b1;
    assign opts.ready   = !out_valid_reg || result.ready;
    assign accept       = opts.valid && opts.ready;

    assign result.valid           = out_valid_reg;
    assign result.found_mptcp     = out_found_reg;
    assign result.found_subtype   = out_sub_reg;
    assign result.subtype_matches = out_match_reg;
    assign result.malformed       = out_mal_reg;

    always_comb
    begin
        b       = opts.option_byte;
        ph_w    = phase_reg;
        skip_w  = skip_reg;
        inmp_w  = in_mptcp_reg;
        found_w = found_reg;
        sub_w   = sub_reg;
        mal_w   = mal_reg;
        cnt_w   = cnt_reg;

        if (cnt_reg >= CNT_W'(MAX_OPTION_BYTES))
        begin
            mal_w = 1'b1;
        end
        else
        begin
            cnt_w = cnt_reg + CNT_W'(1);
            case (phase_reg)
                tomf_pkg::PH_KIND:
                begin
                    if (b == tomf_pkg::KIND_END)
                    begin
                        ph_w = tomf_pkg::PH_DONE;
                    end
                    else if (b != tomf_pkg::KIND_NOOP)
                    begin
                        inmp_w = (b == tomf_pkg::KIND_MPTCP);
                        ph_w   = tomf_pkg::PH_LEN;
                    end
                end
                tomf_pkg::PH_LEN:
                begin
                    // MPTCP needs room for its subtype byte
                    if (b < 8'd2 || (in_mptcp_reg && b < 8'd3))
                    begin
                        mal_w  = 1'b1;
                        inmp_w = 1'b0;
                        ph_w   = tomf_pkg::PH_DONE;
                    end
                    else if (in_mptcp_reg)
                    begin
                        skip_w = b - 8'd2;
                        ph_w   = tomf_pkg::PH_SUB;
                    end
                    else if (b == 8'd2)
                    begin
                        ph_w = tomf_pkg::PH_KIND;
                    end
                    else
                    begin
                        skip_w = b - 8'd2;
                        ph_w   = tomf_pkg::PH_SKIP;
                    end
                end
                tomf_pkg::PH_SUB:
                begin
                    // keep the first MPTCP option only
                    if (!found_reg)
                    begin
                        found_w = 1'b1;
                        sub_w   = b[tomf_pkg::SUBTYPE_SHIFT +: 4];
                    end
                    inmp_w = 1'b0;
                    skip_w = skip_reg - 8'd1;
                    ph_w   = (skip_w != 8'd0) ? tomf_pkg::PH_SKIP : tomf_pkg::PH_KIND;
                end
                tomf_pkg::PH_SKIP:
                begin
                    skip_w = skip_reg - 8'd1;
                    if (skip_w == 8'd0)
                    begin
                        ph_w = tomf_pkg::PH_KIND;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        in_mptcp_next  = in_mptcp_reg;
        found_next     = found_reg;
        sub_next       = sub_reg;
        mal_next       = mal_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_found_next = out_found_reg;
        out_sub_next   = out_sub_reg;
        out_match_next = out_match_reg;
        out_mal_next   = out_mal_reg;

        if (accept)
        begin
            if (opts.area_empty || opts.last_byte)
            begin
                out_valid_next = 1'b1;
                if (opts.area_empty)
                begin
                    out_found_next = 1'b0;
                    out_sub_next   = 4'd0;
                    out_match_next = 1'b0;
                    out_mal_next   = 1'b0;
                end
                else
                begin
                    out_found_next = found_w;
                    out_sub_next   = found_w ? sub_w : 4'd0;
                    out_match_next = found_w && (sub_w == target_reg);
                    out_mal_next   = mal_w ||
                                     (ph_w inside {tomf_pkg::PH_LEN, tomf_pkg::PH_SUB,
                                                   tomf_pkg::PH_SKIP});
                end
                // drop the walk for the next area
                phase_next    = tomf_pkg::PH_KIND;
                skip_next     = 8'd0;
                in_mptcp_next = 1'b0;
                found_next    = 1'b0;
                sub_next      = 4'd0;
                mal_next      = 1'b0;
                cnt_next      = '0;
            end
            else
            begin
                phase_next    = ph_w;
                skip_next     = skip_w;
                in_mptcp_next = inmp_w;
                found_next    = found_w;
                sub_next      = sub_w;
                mal_next      = mal_w;
                cnt_next      = cnt_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tomf_pkg::PH_KIND;
            skip_reg      <= 8'd0;
            in_mptcp_reg  <= 1'b0;
            found_reg     <= 1'b0;
            sub_reg       <= 4'd0;
            mal_reg       <= 1'b0;
            cnt_reg       <= '0;
            target_reg    <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            in_mptcp_reg  <= in_mptcp_next;
            found_reg     <= found_next;
            sub_reg       <= sub_next;
            mal_reg       <= mal_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                target_reg <= cfg.target_subtype;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_sub_reg   <= out_sub_next;
        out_match_reg <= out_match_next;
        out_mal_reg   <= out_mal_next;
    end

    `TOMF_ASSERT_NOW(a_no_sub_without_find,
        out_valid_reg && !out_found_reg, out_sub_reg == 4'd0 && !out_match_reg,
        "subtype reported without an MPTCP option")

    `TOMF_ASSERT_NEXT(a_walk_cleared,
        accept && (opts.last_byte || opts.area_empty),
        phase_reg == tomf_pkg::PH_KIND && cnt_reg == '0 && !found_reg && !mal_reg,
        "walk state not cleared after an area")

    `TOMF_ASSERT_NOW(a_result_from_request,
        $rose(out_valid_reg), $past(accept && (opts.last_byte || opts.area_empty)),
        "result appeared without a closing request")

    `TOMF_ASSERT_NOW(a_count_bound,
        1'b1, cnt_reg <= CNT_W'(MAX_OPTION_BYTES),
        "byte count beyond area limit")

endmodule

`default_nettype wire

[tb/tomf_checker.sv]
`timescale 1ns / 1ps

module tomf_checker #(
    parameter int MAX_BYTES = 40
) (
    input  wire   clk,
    input  wire   rst_n,
    tomf_in_if    opts,
    tomf_out_if   result,
    tomf_cfg_if   cfg,
    output int    mismatches,
    output int    outstanding,
    output int    areas_checked,
    output int    mptcp_areas,
    output int    target_hits,
    output int    malformed_areas
);

    typedef struct packed {
        logic       found;
        logic [3:0] subtype;
        logic       hit;
        logic       bad;
    } area_verdict_t;

    area_verdict_t verdict_q[$];

    // Shadow of the target register and of the option walk
    logic [3:0]       target;
    tomf_pkg::phase_t walk_phase;
    logic [7:0]       bytes_left;
    logic             in_mptcp;
    logic             seen_mptcp;
    logic [3:0]       seen_sub;
    logic             seen_bad;
    int               area_bytes;

    int err_count  = 0;
    int done_count = 0;
    int found_cnt  = 0;
    int hit_cnt    = 0;
    int bad_cnt    = 0;

    assign mismatches      = err_count;
    assign outstanding     = verdict_q.size();
    assign areas_checked   = done_count;
    assign mptcp_areas     = found_cnt;
    assign target_hits     = hit_cnt;
    assign malformed_areas = bad_cnt;

    task automatic report(input string what, input int got, input int want);
        if (err_count < 30)
            $display("%0t: area %0d: %s is %0d, expected %0d", $time, done_count, what, got,
                     want);
        err_count++;
    endtask

    task automatic clear_walk();
        walk_phase = tomf_pkg::PH_KIND;
        bytes_left = '0;
        in_mptcp   = 1'b0;
        seen_mptcp = 1'b0;
        seen_sub   = '0;
        seen_bad   = 1'b0;
        area_bytes = 0;
    endtask

    task automatic walk_byte(input logic [7:0] b);
        case (walk_phase)
            tomf_pkg::PH_KIND: begin
                if (b == tomf_pkg::KIND_END)
                    walk_phase = tomf_pkg::PH_DONE;
                else if (b != tomf_pkg::KIND_NOOP) begin
                    in_mptcp   = (b == tomf_pkg::KIND_MPTCP);
                    walk_phase = tomf_pkg::PH_LEN;
                end
            end
            tomf_pkg::PH_LEN: begin
                // MPTCP needs room for its subtype byte
                if (b < 8'd2 || (in_mptcp && b < 8'd3)) begin
                    seen_bad   = 1'b1;
                    in_mptcp   = 1'b0;
                    walk_phase = tomf_pkg::PH_DONE;
                end else if (in_mptcp) begin
                    bytes_left = b - 8'd2;
                    walk_phase = tomf_pkg::PH_SUB;
                end else if (b == 8'd2)
                    walk_phase = tomf_pkg::PH_KIND;
                else begin
                    bytes_left = b - 8'd2;
                    walk_phase = tomf_pkg::PH_SKIP;
                end
            end
            tomf_pkg::PH_SUB: begin
                // keep only the first MPTCP option of the area
                if (!seen_mptcp) begin
                    seen_mptcp = 1'b1;
                    seen_sub   = 4'(b >> tomf_pkg::SUBTYPE_SHIFT);
                end
                in_mptcp   = 1'b0;
                bytes_left = bytes_left - 8'd1;
                walk_phase = (bytes_left != 8'd0) ? tomf_pkg::PH_SKIP : tomf_pkg::PH_KIND;
            end
            tomf_pkg::PH_SKIP: begin
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                    walk_phase = tomf_pkg::PH_KIND;
            end
            default: ;
        endcase
    endtask

    task automatic take_request(input logic [7:0] b, input logic last, input logic empty);
        area_verdict_t v;
        v = '0;
        if (empty) begin
            clear_walk();
            verdict_q.push_back(v);
            return;
        end
        if (area_bytes >= MAX_BYTES)
            seen_bad = 1'b1;
        else begin
            area_bytes++;
            walk_byte(b);
        end
        if (last) begin
            v.found   = seen_mptcp;
            v.subtype = seen_mptcp ? seen_sub : 4'd0;
            v.hit     = seen_mptcp && (seen_sub == target);
            v.bad     = seen_bad ||
                        (walk_phase inside {tomf_pkg::PH_LEN, tomf_pkg::PH_SUB,
                                            tomf_pkg::PH_SKIP});
            verdict_q.push_back(v);
            clear_walk();
        end
    endtask

    task automatic check_result();
        area_verdict_t v;
        if (verdict_q.size() == 0) begin
            report("result with nothing pending", 1, 0);
            return;
        end
        v = verdict_q.pop_front();
        if (result.found_mptcp !== v.found)
            report("found_mptcp", result.found_mptcp, v.found);
        if (result.found_subtype !== v.subtype)
            report("found_subtype", result.found_subtype, v.subtype);
        if (result.subtype_matches !== v.hit)
            report("subtype_matches", result.subtype_matches, v.hit);
        if (result.malformed !== v.bad)
            report("malformed", result.malformed, v.bad);
        done_count++;
        found_cnt += v.found;
        hit_cnt   += v.hit;
        bad_cnt   += v.bad;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            target = '0;
            clear_walk();
            verdict_q.delete();
        end else begin
            if (cfg.valid && cfg.ready)
                target = cfg.target_subtype;
            if (opts.valid && opts.ready)
                take_request(opts.option_byte, opts.last_byte, opts.area_empty);
            if (result.valid && result.ready)
                check_result();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int MAX_BYTES    = 40;
    localparam int SETTLE       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 300;

    logic clk;
    logic rst_n;

    tomf_in_if  opts();
    tomf_out_if result();
    tomf_cfg_if cfg();

    int mismatches;
    int outstanding;
    int areas_checked;
    int mptcp_areas;
    int target_hits;
    int malformed_areas;

    int         in_idle_pct  = 0;
    int         out_idle_pct = 0;
    int         hold_request = 0;
    int         items_sent   = 0;
    int         cycle_count  = 0;
    logic [3:0] cur_target   = '0;
    logic [7:0] pkt[$];

    tcp_option_mptcp_finder #(
        .MAX_OPTION_BYTES(MAX_BYTES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .opts   (opts),
        .result (result)
    );

    tomf_checker #(
        .MAX_BYTES(MAX_BYTES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .opts            (opts),
        .result          (result),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .areas_checked   (areas_checked),
        .mptcp_areas     (mptcp_areas),
        .target_hits     (target_hits),
        .malformed_areas (malformed_areas)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run timed out after %0d cycles, %0d results still pending", cycle_count,
                 outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off on request
    initial
    begin
        int hold_left;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                result.ready <= 1'b0;
                hold_left    = hold_request;
                hold_request = 0;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            else
                result.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    task automatic send_req(input logic [7:0] b, input logic last, input logic empty);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            opts.valid <= 1'b0;
            @(posedge clk);
        end
        opts.valid       <= 1'b1;
        opts.option_byte <= b;
        opts.last_byte   <= last;
        opts.area_empty  <= empty;
        do @(posedge clk); while (!opts.ready);
        items_sent++;
    endtask

    // Send pkt as one area; optionally abandon it with an empty-area request
    task automatic send_area(input bit end_empty);
        for (int i = 0; i < pkt.size(); i++)
            send_req(pkt[i], (i == pkt.size() - 1) && !end_empty, 1'b0);
        if (end_empty)
            send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic wait_idle(input bit settle);
        opts.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_target(input logic [3:0] value);
        cfg.valid          <= 1'b1;
        cfg.target_subtype <= value;
        cur_target = value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic push_filler(input int n);
        for (int i = 0; i < n; i++)
            pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    // A legal option list: no-ops, MPTCP, other kinds, maybe an end of list
    task automatic build_clean();
        int         n_opts;
        int         pick;
        int         len;
        logic [7:0] kind;
        logic [3:0] sub;
        pkt.delete();
        n_opts = $urandom_range(1, 4);
        for (int i = 0; i < n_opts; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                pkt.push_back(tomf_pkg::KIND_NOOP);
            else if (pick < 6)
            begin
                len = $urandom_range(3, 8);
                sub = ($urandom_range(0, 2) == 0) ? cur_target : 4'($urandom_range(0, 15));
                pkt.push_back(tomf_pkg::KIND_MPTCP);
                pkt.push_back(8'(len));
                pkt.push_back({sub, 4'($urandom_range(0, 15))});
                push_filler(len - 3);
            end
            else if (pick < 9)
            begin
                kind = 8'($urandom_range(2, 255));
                if (kind == tomf_pkg::KIND_MPTCP)
                    kind = 8'd8;
                len = $urandom_range(2, 10);
                pkt.push_back(kind);
                pkt.push_back(8'(len));
                push_filler(len - 2);
            end
            else
            begin
                pkt.push_back(tomf_pkg::KIND_END);
                push_filler($urandom_range(0, 4));
                break;
            end
        end
    endtask

    // Too-short length byte at the tail, ordinary kind or MPTCP
    task automatic append_short();
        if ($urandom_range(0, 1) == 0)
        begin
            pkt.push_back(tomf_pkg::KIND_MPTCP);
            pkt.push_back(8'($urandom_range(0, 2)));
        end
        else
        begin
            pkt.push_back(8'($urandom_range(2, 255)));
            pkt.push_back(8'($urandom_range(0, 1)));
        end
        push_filler($urandom_range(0, 3));
    endtask

    // Area near, at or past the byte limit
    task automatic build_long();
        int n;
        n = $urandom_range(MAX_BYTES - 2, MAX_BYTES + 4);
        pkt.delete();
        if ($urandom_range(0, 1) == 0)
        begin
            pkt.push_back(tomf_pkg::KIND_MPTCP);
            pkt.push_back(8'd3);
            pkt.push_back({4'($urandom_range(0, 15)), 4'h0});
        end
        while (pkt.size() < n)
            pkt.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : tomf_pkg::KIND_NOOP);
    endtask

    task automatic run_directed();
        send_req(8'hFF, 1'b0, 1'b1);
        pkt = '{tomf_pkg::KIND_END};
        send_area(0);
        pkt = '{tomf_pkg::KIND_MPTCP, 8'd3, 8'hF5};
        send_area(0);
        pkt = '{tomf_pkg::KIND_MPTCP, 8'd1};
        send_area(0);
        pkt = '{tomf_pkg::KIND_MPTCP, 8'd2, 8'h77};
        send_area(0);
        pkt = '{8'd8, 8'd10, 8'hFF};
        send_area(0);
        pkt = '{tomf_pkg::KIND_END, 8'hFF};
        send_area(0);
        // first MPTCP option wins over a later one
        pkt = '{tomf_pkg::KIND_NOOP, tomf_pkg::KIND_MPTCP, 8'd3, 8'h00,
                tomf_pkg::KIND_MPTCP, 8'd3, 8'hF0};
        send_area(0);
        pkt = '{tomf_pkg::KIND_MPTCP, 8'd4, 8'hE0};
        send_area(0);
        pkt = '{tomf_pkg::KIND_MPTCP};
        send_area(1);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int pick;
        bit paused;
        stop_at = items_sent + count;
        paused  = 0;
        while (items_sent < stop_at)
        begin
            // drain once mid-phase with the sender parked
            if (!paused && items_sent >= stop_at - count / 2)
            begin
                wait_idle(1'b0);
                paused = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            else if (pick < 70)
            begin
                build_clean();
                send_area(0);
            end
            else if (pick < 82)
            begin
                build_clean();
                pick = $urandom_range(1, pkt.size());
                while (pkt.size() > pick)
                    void'(pkt.pop_back());
                send_area(0);
            end
            else if (pick < 90)
            begin
                build_clean();
                append_short();
                send_area(0);
            end
            else if (pick < 97)
            begin
                pkt.delete();
                push_filler($urandom_range(1, 12));
                send_area($urandom_range(0, 1));
            end
            else
            begin
                build_long();
                send_area(0);
            end
        end
    endtask

    initial
    begin
        opts.valid         <= 1'b0;
        opts.option_byte   <= '0;
        opts.last_byte     <= 1'b0;
        opts.area_empty    <= 1'b0;
        cfg.valid          <= 1'b0;
        cfg.target_subtype <= '0;
        rst_n              <= 1'b0;
        in_idle_pct  = 31;
        out_idle_pct = 53;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_target(4'd15);
        run_directed();
        wait_idle(1'b1);
        write_target(4'd1);
        run_random(PHASE_ITEMS);

        wait_idle(1'b1);
        write_target(4'd0);
        in_idle_pct  = 53;
        out_idle_pct = 31;
        run_random(PHASE_ITEMS);

        wait_idle(1'b1);
        write_target(4'($urandom_range(2, 14)));
        in_idle_pct  = 0;
        out_idle_pct = 0;
        // block the result side while requests keep coming
        hold_request = 120;
        run_random(PHASE_ITEMS);

        wait_idle(1'b1);
        $display("sent %0d option requests, checked %0d areas over targets 15, 1, 0 and %0d",
                 items_sent, areas_checked, cur_target);
        $display("areas with MPTCP: %0d, target matches: %0d, malformed: %0d, mismatches: %0d",
                 mptcp_areas, target_hits, malformed_areas, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
